// ===== hw/rtl/sha256_pkg.sv =====
// sha256_pkg: shared types, constants and tables for the sha256 stream hasher
// used by the modules sha256_core and sha256_stream_hash
// depends on nothing
package sha256_pkg;

  localparam int WORD_W      = 32;
  localparam int BUF_DEPTH   = 16;   // 32-bit words in one 64-byte block
  localparam int CHAIN_DEPTH = 8;    // chaining words
  localparam int ROUNDS      = 64;
  localparam int BLK_CNT_W   = 55;   // message length in whole blocks (64 - 9 bits)

  // round constants
  localparam logic [31:0] K_TABLE [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // initial hash values
  localparam logic [31:0] IV_TABLE [CHAIN_DEPTH] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LOAD,
    S_ROUND,
    S_UPDATE,
    S_OUT
  } st_t;

  // sequencer controls for the round datapath
  typedef struct packed {
    logic       load_var;    // shift a chaining word into the working variables
    logic       rot_var;     // rotate working variables during chain update
    logic       run_round;   // one compression round
    logic       sched_load;  // shift a block word into the schedule
    logic       sched_calc;  // shift a computed schedule word
    logic [5:0] round_idx;
  } core_ctrl_t;

endpackage

// ===== hw/rtl/sha256_ifs.sv =====
// sha256_ifs: valid/ready channel interfaces for message bytes and digest words
// no dependencies
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, output data_byte, output byte_present,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input byte_present,
                  input end_of_message, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

// ===== hw/rtl/sha256_ram.sv =====
// sha256_ram: generic single-write, single-read ram with registered read data
// no dependencies
module sha256_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/sha256_core.sv =====
// sha256_core: working variables, 16-word message schedule and one round per cycle
// depends on sha256_pkg
module sha256_core import sha256_pkg::*; (
  input  logic              clk,
  input  core_ctrl_t        ctrl,
  input  logic [WORD_W-1:0] chain_rd,
  input  logic [WORD_W-1:0] word_in,
  output logic [WORD_W-1:0] a_out
);

  logic [WORD_W-1:0] a, b, c, d, e, f, g, h;
  logic [WORD_W-1:0] sched [BUF_DEPTH];
  logic [WORD_W-1:0] t1, t2, w_new, sched_in;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // round function
  always_comb begin
    t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + K_TABLE[ctrl.round_idx] + sched[BUF_DEPTH-1];
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
  end

  // next schedule word from the 16-word window
  always_comb begin
    w_new = (rotr(sched[14], 17) ^ rotr(sched[14], 19) ^ (sched[14] >> 10))
            + sched[9]
            + (rotr(sched[1], 7) ^ rotr(sched[1], 18) ^ (sched[1] >> 3))
            + sched[0];
    sched_in = ctrl.sched_calc ? w_new : word_in;
  end

  // working variables
  always_ff @(posedge clk) begin
    if (ctrl.load_var) begin
      a <= b; b <= c; c <= d; d <= e; e <= f; f <= g; g <= h; h <= chain_rd;
    end else if (ctrl.rot_var) begin
      a <= b; b <= c; c <= d; d <= e; e <= f; f <= g; g <= h; h <= a;
    end else if (ctrl.run_round) begin
      h <= g; g <= f; f <= e; e <= d + t1;
      d <= c; c <= b; b <= a; a <= t1 + t2;
    end
  end

  // schedule window, newest word at the top
  always_ff @(posedge clk) begin
    if (ctrl.sched_load || ctrl.sched_calc) begin
      for (int i = 0; i < BUF_DEPTH - 1; i++) begin
        sched[i] <= sched[i+1];
      end
      sched[BUF_DEPTH-1] <= sched_in;
    end
  end

  assign a_out = a;

endmodule

// ===== hw/rtl/sha256_stream_hash.sv =====
// Streaming SHA-256 hasher. Message bytes arrive one per transaction on msg;
// a transaction with end_of_message set (with or without a byte) pads the
// message, runs the final block or blocks and returns the digest as eight
// transactions on digest, word 0 (most significant) first, then restarts for
// the next message. Bytes are taken one per cycle while the block is idle.
// Completing a 64-byte block reads the chaining RAM into the working
// variables, runs 64 rounds of the single round unit, then adds back and
// writes the chaining RAM through its single write port. A finish adds a
// padding step and one final block (two when the length spills into a
// second block), then reads each digest word through the chaining RAM read port.
// Block data lives in a 16x32 RAM, chaining words in an 8x32 RAM.
// depends on sha256_pkg, sha256_ifs, sha256_ram, sha256_core
module sha256_stream_hash import sha256_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  sha256_in_if.sink    msg,
  sha256_out_if.source digest
);

  st_t                  state, state_next;
  logic [5:0]           cnt;
  logic [5:0]           fill;
  logic [23:0]          acc;
  logic [BLK_CNT_W-1:0] blk_count;
  logic                 fresh;
  logic                 has_pad;
  logic                 has_len;
  logic                 fin_pend;
  logic                 rd_ok;
  logic [2:0]           chain_raddr_q;
  logic [3:0]           buf_raddr_q;

  logic                 out_valid;
  logic [WORD_W-1:0]    out_word;
  logic [2:0]           out_index;
  logic                 out_last;

  logic                 in_acc;
  logic                 out_load;
  logic                 count_en;

  logic                 chain_we;
  logic [2:0]           chain_waddr, chain_raddr;
  logic [WORD_W-1:0]    chain_wdata, chain_rdata, chain_rd;
  logic                 buf_we;
  logic [3:0]           buf_waddr, buf_raddr;
  logic [WORD_W-1:0]    buf_wdata, buf_rdata, word_in;
  logic [63:0]          msg_len;
  logic [WORD_W-1:0]    pad_word;
  core_ctrl_t           core_ctrl;
  logic [WORD_W-1:0]    a_out;

  // chaining words and block buffer
  sha256_ram #(.WIDTH(WORD_W), .DEPTH(CHAIN_DEPTH)) u_chain_ram (
    .clk   (clk),
    .we    (chain_we),
    .waddr (chain_waddr),
    .wdata (chain_wdata),
    .raddr (chain_raddr),
    .rdata (chain_rdata)
  );

  sha256_ram #(.WIDTH(WORD_W), .DEPTH(BUF_DEPTH)) u_buf_ram (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  sha256_core u_core (
    .clk      (clk),
    .ctrl     (core_ctrl),
    .chain_rd (chain_rd),
    .word_in  (word_in),
    .a_out    (a_out)
  );

  // chaining RAM reads as the initial hash until the message's first block is written back
  assign chain_rd = fresh ? IV_TABLE[chain_raddr_q] : chain_rdata;

  // padding and length words; the length is a whole number of blocks plus the fill
  assign msg_len = {blk_count, fill, 3'b000};

  always_comb begin
    case (fill[1:0])
      2'd0:    pad_word = {PAD_BYTE, 24'h0};
      2'd1:    pad_word = {acc[7:0], PAD_BYTE, 16'h0};
      2'd2:    pad_word = {acc[15:0], PAD_BYTE, 8'h0};
      default: pad_word = {acc[23:0], PAD_BYTE};
    endcase
  end

  // block word source: buffer, pad word, zero or length
  always_comb begin
    if (!has_pad && !has_len) begin
      word_in = buf_rdata;
    end else if (has_pad && (buf_raddr_q < fill[5:2])) begin
      word_in = buf_rdata;
    end else if (has_pad && (buf_raddr_q == fill[5:2])) begin
      word_in = pad_word;
    end else if (has_len && (buf_raddr_q == 4'd14)) begin
      word_in = msg_len[63:32];
    end else if (has_len && (buf_raddr_q == 4'd15)) begin
      word_in = msg_len[31:0];
    end else begin
      word_in = '0;
    end
  end

  assign in_acc   = msg.valid && msg.ready;
  assign out_load = (state == S_OUT) && rd_ok && (!out_valid || digest.ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (msg.byte_present && (fill == 6'd63)) begin
            state_next = S_LOAD;
          end else if (msg.end_of_message) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (cnt == 6'd8) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        if (cnt == 6'd63) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (cnt == 6'd8) begin
          if (has_len) begin
            state_next = S_OUT;
          end else if (has_pad) begin
            state_next = S_LOAD;
          end else if (fin_pend) begin
            state_next = S_PAD;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_OUT: begin
        if (out_load && (cnt == 6'd7)) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // datapath and memory controls
  always_comb begin
    msg.ready            = 1'b0;
    count_en             = 1'b0;
    chain_raddr          = cnt[2:0];
    chain_we             = 1'b0;
    chain_waddr          = chain_raddr_q;
    chain_wdata          = a_out + chain_rd;
    buf_we               = 1'b0;
    buf_waddr            = fill[5:2];
    buf_wdata            = {acc, msg.data_byte};
    buf_raddr            = '0;
    core_ctrl            = '0;
    core_ctrl.round_idx  = cnt;
    case (state)
      S_IDLE: begin
        msg.ready = 1'b1;
        buf_we    = in_acc && msg.byte_present && (fill[1:0] == 2'd3);
      end
      S_LOAD: begin
        count_en             = 1'b1;
        buf_raddr            = (cnt == 6'd8) ? 4'd1 : 4'd0;
        core_ctrl.load_var   = (cnt != 6'd0);
        core_ctrl.sched_load = (cnt == 6'd8);
      end
      S_ROUND: begin
        count_en             = 1'b1;
        buf_raddr            = 4'(cnt + 6'd2);
        core_ctrl.run_round  = 1'b1;
        core_ctrl.sched_load = (cnt < 6'd15);
        core_ctrl.sched_calc = (cnt >= 6'd15);
      end
      S_UPDATE: begin
        count_en          = 1'b1;
        chain_we          = (cnt != 6'd0);
        core_ctrl.rot_var = (cnt != 6'd0);
      end
      S_OUT: begin
        count_en = out_load;
      end
      default: begin
        msg.ready = 1'b0;
      end
    endcase
  end

  // state and sequence counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        cnt <= '0;
      end else if (count_en) begin
        cnt <= cnt + 6'd1;
      end
    end
  end

  // message bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      blk_count <= '0;
      fresh     <= 1'b1;
      has_pad   <= 1'b0;
      has_len   <= 1'b0;
      fin_pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc && msg.byte_present) begin
            fill <= fill + 6'd1;
            if (fill == 6'd63) begin
              blk_count <= blk_count + BLK_CNT_W'(1);
              has_pad   <= 1'b0;
              has_len   <= 1'b0;
              fin_pend  <= msg.end_of_message;
            end
          end
        end
        S_PAD: begin
          has_pad  <= 1'b1;
          has_len  <= (fill[5:3] != 3'b111);
          fin_pend <= 1'b0;
        end
        S_UPDATE: begin
          if (cnt == 6'd8) begin
            fresh <= 1'b0;
            if (has_pad && !has_len) begin
              has_pad <= 1'b0;
              has_len <= 1'b1;
            end
          end
        end
        S_OUT: begin
          if (out_load && (cnt == 6'd7)) begin
            fill      <= '0;
            blk_count <= '0;
            fresh     <= 1'b1;
            has_pad   <= 1'b0;
            has_len   <= 1'b0;
          end
        end
        default: begin
          fin_pend <= fin_pend;
        end
      endcase
    end
  end

  // partial word of incoming bytes and read address tracking
  always_ff @(posedge clk) begin
    if (in_acc && msg.byte_present) begin
      acc <= {acc[15:0], msg.data_byte};
    end
    chain_raddr_q <= chain_raddr;
    buf_raddr_q   <= buf_raddr;
  end

  // digest read pacing: read data is good in the cycle after the address settles
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok <= 1'b0;
    end else begin
      rd_ok <= (state == S_OUT) && !out_load;
    end
  end

  // digest output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (digest.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word  <= chain_rd;
      out_index <= cnt[2:0];
      out_last  <= (cnt == 6'd7);
    end
  end

  assign digest.valid       = out_valid;
  assign digest.digest_word = out_word;
  assign digest.word_index  = out_index;
  assign digest.last_word   = out_last;

`ifndef SYNTHESIS
  // a digest word other than the last can only be pending while the readout runs
  a_out_in_readout: assert property (@(posedge clk) disable iff (rst)
    (digest.valid && !digest.last_word) |-> (state == S_OUT))
    else $error("digest word pending outside readout");

  // rounds advance one per cycle without a gap
  a_round_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && cnt != 6'd63) |=> (state == S_ROUND && cnt == $past(cnt) + 6'd1))
    else $error("round counter skipped");

  // pad and length share a block only when the pad lands before the length words
  a_pad_len_fit: assert property (@(posedge clk) disable iff (rst)
    (has_pad && has_len) |-> (fill[5:3] != 3'b111))
    else $error("pad and length overlap");
`endif

endmodule
